[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, disabled while reset is high.
`define HPDD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hpdd check failed");

// Check a property on every rising edge, reset included.
`define HPDD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("hpdd check failed");

`endif

[hw/rtl/hpdd_pkg.sv]
// Shared types, widths and constants of the heading PID block.
package hpdd_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int INTEGRAL_WIDTH_DEF  = 40;

   localparam int GAIN_W     = 16;
   localparam int BEARING_W  = 17;
   localparam int ROTATION_W = 18;
   localparam int DIST_W     = 16;
   localparam int PULSE_W    = 11;
   localparam int TURN_W     = 16;
   localparam int ERR_W      = 19;
   localparam int DIFF_W     = 20;
   localparam int PROD_E_W   = 35;
   localparam int DERIV_W    = 36;
   localparam int SIDE_W     = 17;
   localparam int PSUM_W     = 23;
   localparam int KI_SHIFT   = 16;
   localparam int CSR_IDX_W  = 3;

   localparam logic signed [GAIN_W-1:0] KP_RESET             = 16'sd256;
   localparam logic signed [GAIN_W-1:0] KI_RESET             = 16'sd0;
   localparam logic signed [GAIN_W-1:0] KD_RESET             = 16'sd0;
   localparam logic        [GAIN_W-1:0] LOOP_PERIOD_RESET    = 16'd6554;
   localparam logic        [GAIN_W-1:0] INVERSE_PERIOD_RESET = 16'd10;
   localparam logic signed [GAIN_W-1:0] FORWARD_SPEED_RESET  = 16'sd16384;
   localparam logic        [GAIN_W-1:0] ARRIVAL_RADIUS_RESET = 16'd30;

   localparam logic signed [SIDE_W-1:0] SIDE_MAX     = 17'sd32768;
   localparam logic signed [SIDE_W-1:0] SIDE_MIN     = -17'sd32768;
   localparam logic signed [PSUM_W-1:0] PULSE_ROUND  = 23'sd16384;
   localparam logic signed [PSUM_W-1:0] PULSE_CENTRE = 23'sd1100;
   localparam int                       PULSE_FRAC   = 15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP_GAIN        = 3'd0,
      CSR_KI_GAIN        = 3'd1,
      CSR_KD_GAIN        = 3'd2,
      CSR_LOOP_PERIOD    = 3'd3,
      CSR_INVERSE_PERIOD = 3'd4,
      CSR_FORWARD_SPEED  = 3'd5,
      CSR_ARRIVAL_RADIUS = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic start;
      logic b_signed;
   } hpdd_mul_ctl_type;

endpackage

[hw/rtl/heading_pid_differential_drive.sv]
// Heading PID controller with differential-drive mixing to two motor pulse widths.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  bearings, compass rotation, distance
//   rsp      out        rsp_valid / rsp_ready  left and right pulse width, turn command
//   csr      in         csr_valid / csr_ready  register index, write data
//
// A request that is acted on passes its five products one after another through one
// bit-serial multiplier, then the ST_SAT and ST_OUT states, before rsp_valid rises.
// A request inside the arrival radius is dropped in its acceptance cycle.
// Synchronous reset restores the register reset values and clears the loop state.
// The result sits in an output register, so the next request is taken while it waits;
// a stalled result holds the sequencer in its final state until rsp_ready.
module heading_pid_differential_drive import hpdd_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int INTEGRAL_WIDTH  = INTEGRAL_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [BEARING_W-1:0]         req_target_bearing,
   input  logic [BEARING_W-1:0]         req_north_bearing,
   input  logic signed [ROTATION_W-1:0] req_compass_rotation,
   input  logic [DIST_W-1:0]            req_distance_dm,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [PULSE_W-1:0]           rsp_left_pulse_us,
   output logic [PULSE_W-1:0]           rsp_right_pulse_us,
   output logic signed [TURN_W-1:0]     rsp_turn_command,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [GAIN_W-1:0]            csr_data
);

   localparam int IW   = INTEGRAL_WIDTH;
   localparam int AW   = (IW > DERIV_W) ? IW : DERIV_W;
   localparam int PW   = (IW + KI_SHIFT > 52) ? IW + KI_SHIFT : 52;
   localparam int SW   = PW + 4;
   localparam int SUMW = ((IW > PROD_E_W) ? IW : PROD_E_W) + 1;
   localparam int SR   = (ANGLE_FRAC_BITS >= 7) ? ANGLE_FRAC_BITS - 7 : 0;
   localparam int SL   = (ANGLE_FRAC_BITS < 7) ? 7 - ANGLE_FRAC_BITS : 0;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL_I, ST_MUL_D, ST_MUL_P, ST_MUL_KD, ST_MUL_KI, ST_SAT, ST_OUT
   } state_type;

   function automatic logic [PULSE_W-1:0] pulse_of(input logic signed [SIDE_W-1:0] side);
      logic signed [PSUM_W-1:0] x;
      logic signed [PSUM_W-1:0] q;
      // 100 * side as 64 + 32 + 4
      x = (PSUM_W'(side) <<< 6) + (PSUM_W'(side) <<< 5) + (PSUM_W'(side) <<< 2)
          + PULSE_ROUND;
      q = (x >>> PULSE_FRAC) + PULSE_CENTRE;
      return q[PULSE_W-1:0];
   endfunction

   logic signed [GAIN_W-1:0] kp_ff, ki_ff, kd_ff, fs_ff;
   logic [GAIN_W-1:0]        lp_ff, inv_ff, radius_ff;

   state_type                state_ff, state_in;
   logic signed [ERR_W-1:0]  e_ff, e_in;
   logic signed [ERR_W-1:0]  last_ff, last_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [IW-1:0]     int_ff, int_in;
   logic signed [DERIV_W-1:0] d_ff, d_in;
   logic signed [SW-1:0]     s_ff, s_in;
   logic signed [TURN_W-1:0] turn_ff, turn_in;
   logic signed [SIDE_W-1:0] l_ff, l_in, r_ff, r_in;
   logic signed [AW-1:0]     mul_a_ff, mul_a_in;
   logic [GAIN_W-1:0]        mul_b_ff, mul_b_in;
   hpdd_mul_ctl_type         mul_ctl_ff, mul_ctl_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PULSE_W-1:0]       rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic signed [TURN_W-1:0] rsp_turn_ff, rsp_turn_in;

   logic [PW-1:0]            mul_prod;
   logic                     mul_done;

   logic signed [DIFF_W-1:0] e_raw;
   logic signed [ERR_W-1:0]  e_sat;
   logic signed [SUMW-1:0]   int_sum;
   logic signed [IW-1:0]     int_sat;
   logic signed [SW-1:0]     s_scaled;
   logic signed [TURN_W-1:0] turn_sat;
   logic signed [SIDE_W-1:0] l_sum, r_sum;

   hpdd_smul #(.AW(AW), .PW(PW)) u_smul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl_ff),
      .a     (mul_a_ff),
      .b     (mul_b_ff),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= KP_RESET;
         ki_ff     <= KI_RESET;
         kd_ff     <= KD_RESET;
         lp_ff     <= LOOP_PERIOD_RESET;
         inv_ff    <= INVERSE_PERIOD_RESET;
         fs_ff     <= FORWARD_SPEED_RESET;
         radius_ff <= ARRIVAL_RADIUS_RESET;
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            CSR_KP_GAIN:        kp_ff     <= $signed(csr_data);
            CSR_KI_GAIN:        ki_ff     <= $signed(csr_data);
            CSR_KD_GAIN:        kd_ff     <= $signed(csr_data);
            CSR_LOOP_PERIOD:    lp_ff     <= csr_data;
            CSR_INVERSE_PERIOD: inv_ff    <= csr_data;
            CSR_FORWARD_SPEED:  fs_ff     <= $signed(csr_data);
            CSR_ARRIVAL_RADIUS: radius_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      e_raw = $signed({3'b000, req_target_bearing}) - $signed({3'b000, req_north_bearing})
              - DIFF_W'(req_compass_rotation);
      if (e_raw[DIFF_W-1] != e_raw[DIFF_W-2]) begin
         e_sat = e_raw[DIFF_W-1] ? {1'b1, {(ERR_W-1){1'b0}}} : {1'b0, {(ERR_W-1){1'b1}}};
      end else begin
         e_sat = e_raw[ERR_W-1:0];
      end

      int_sum = SUMW'(int_ff) + SUMW'($signed(mul_prod[PROD_E_W-1:0]));
      if ((int_sum[SUMW-1:IW-1] != '0) && (int_sum[SUMW-1:IW-1] != '1)) begin
         int_sat = int_sum[SUMW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
      end else begin
         int_sat = int_sum[IW-1:0];
      end

      s_scaled = (ANGLE_FRAC_BITS >= 7) ? (s_ff >>> SR) : (s_ff <<< SL);
      if ((s_scaled[SW-1:TURN_W-1] != '0) && (s_scaled[SW-1:TURN_W-1] != '1)) begin
         turn_sat = s_scaled[SW-1] ? {1'b1, {(TURN_W-1){1'b0}}}
                                   : {1'b0, {(TURN_W-1){1'b1}}};
      end else begin
         turn_sat = s_scaled[TURN_W-1:0];
      end

      l_sum = SIDE_W'(fs_ff) + SIDE_W'(turn_ff);
      r_sum = SIDE_W'(fs_ff) - SIDE_W'(turn_ff);
   end

   always_comb begin
      state_in     = state_ff;
      e_in         = e_ff;
      last_in      = last_ff;
      diff_in      = diff_ff;
      int_in       = int_ff;
      d_in         = d_ff;
      s_in         = s_ff;
      turn_in      = turn_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      mul_ctl_in   = '{start: 1'b0, b_signed: mul_ctl_ff.b_signed};
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_turn_in  = rsp_turn_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_distance_dm >= radius_ff)) begin
               e_in       = e_sat;
               diff_in    = DIFF_W'(e_sat) - DIFF_W'(last_ff);
               last_in    = e_sat;
               mul_a_in   = AW'(e_sat);
               mul_b_in   = lp_ff;
               mul_ctl_in = '{start: 1'b1, b_signed: 1'b0};
               state_in   = ST_MUL_I;
            end
         end
         ST_MUL_I: begin
            if (mul_done) begin
               int_in     = int_sat;
               mul_a_in   = AW'(diff_ff);
               mul_b_in   = inv_ff;
               mul_ctl_in = '{start: 1'b1, b_signed: 1'b0};
               state_in   = ST_MUL_D;
            end
         end
         ST_MUL_D: begin
            if (mul_done) begin
               d_in       = $signed(mul_prod[DERIV_W-1:0]);
               mul_a_in   = AW'(e_ff);
               mul_b_in   = kp_ff;
               mul_ctl_in = '{start: 1'b1, b_signed: 1'b1};
               state_in   = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            if (mul_done) begin
               s_in       = SW'($signed(mul_prod));
               mul_a_in   = AW'(d_ff);
               mul_b_in   = kd_ff;
               mul_ctl_in = '{start: 1'b1, b_signed: 1'b1};
               state_in   = ST_MUL_KD;
            end
         end
         ST_MUL_KD: begin
            if (mul_done) begin
               s_in       = s_ff + SW'($signed(mul_prod));
               mul_a_in   = AW'(int_ff);
               mul_b_in   = ki_ff;
               mul_ctl_in = '{start: 1'b1, b_signed: 1'b1};
               state_in   = ST_MUL_KI;
            end
         end
         ST_MUL_KI: begin
            if (mul_done) begin
               s_in     = s_ff + SW'($signed(mul_prod) >>> KI_SHIFT);
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            turn_in  = turn_sat;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            l_in = (l_sum > SIDE_MAX) ? SIDE_MAX : ((l_sum < SIDE_MIN) ? SIDE_MIN : l_sum);
            r_in = (r_sum > SIDE_MAX) ? SIDE_MAX : ((r_sum < SIDE_MIN) ? SIDE_MIN : r_sum);
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_left_in  = pulse_of(l_in);
               rsp_right_in = pulse_of(r_in);
               rsp_turn_in  = turn_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         int_ff       <= '0;
         mul_ctl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         int_ff       <= int_in;
         mul_ctl_ff   <= mul_ctl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      e_ff         <= e_in;
      diff_ff      <= diff_in;
      d_ff         <= d_in;
      s_ff         <= s_in;
      turn_ff      <= turn_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_turn_ff  <= rsp_turn_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_pulse_us  = rsp_left_ff;
   assign rsp_right_pulse_us = rsp_right_ff;
   assign rsp_turn_command   = rsp_turn_ff;

endmodule

[hw/rtl/hpdd_smul.sv]
// Bit-serial shift-add multiplier: one bit of the 16-bit gain operand per cycle.
module hpdd_smul import hpdd_pkg::*; #(
   parameter int AW = 40,
   parameter int PW = 56
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hpdd_mul_ctl_type     ctl,
   input  logic signed [AW-1:0] a,
   input  logic [GAIN_W-1:0]    b,
   output logic [PW-1:0]        prod,
   output logic                 done
);

   localparam int CNT_W = $clog2(GAIN_W);

   logic signed [PW-1:0] a_ff, a_in;
   logic [GAIN_W-1:0]    b_ff, b_in;
   logic [PW-1:0]        acc_ff, acc_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 sgn_ff, sgn_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 last;
   logic signed [PW-1:0] addend;

   always_comb begin
      last    = (cnt_ff == CNT_W'(GAIN_W - 1));
      addend  = (sgn_ff && last) ? -a_ff : a_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      sgn_in  = sgn_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         a_in    = PW'(a);
         b_in    = b;
         acc_in  = '0;
         cnt_in  = '0;
         sgn_in  = ctl.b_signed;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + addend;
         end
         a_in   = a_ff <<< 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      sgn_ff <= sgn_in;
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

[hw/rtl/hpdd_checker.sv]
// Port-level checks of the heading PID block and their bind to the top level.
`include "assert_macros.svh"

module hpdd_checker import hpdd_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [PULSE_W-1:0]           rsp_left_pulse_us,
   input logic [PULSE_W-1:0]           rsp_right_pulse_us,
   input logic signed [TURN_W-1:0]     rsp_turn_command
);

   `HPDD_ASSERT(a_pulse_range, clock, reset, rsp_valid |-> (rsp_left_pulse_us >= 11'd1000) && (rsp_left_pulse_us <= 11'd1200) && (rsp_right_pulse_us >= 11'd1000) && (rsp_right_pulse_us <= 11'd1200))
   `HPDD_ASSERT(a_turn_left, clock, reset, (rsp_valid && !rsp_turn_command[TURN_W-1]) |-> (rsp_left_pulse_us >= rsp_right_pulse_us))
   `HPDD_ASSERT(a_turn_right, clock, reset, (rsp_valid && rsp_turn_command[TURN_W-1]) |-> (rsp_left_pulse_us <= rsp_right_pulse_us))
   `HPDD_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid)
   `HPDD_ASSERT(a_rsp_stable, clock, reset, (rsp_valid && !rsp_ready) |=> ($stable(rsp_left_pulse_us) && $stable(rsp_right_pulse_us) && $stable(rsp_turn_command)))

endmodule

bind heading_pid_differential_drive hpdd_checker u_hpdd_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for the heading PID controller with differential-drive mixing.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hpdd_pkg::*;

   localparam int     RESET_CYCLES   = 11;
   localparam int     SETTLE_CYCLES  = 120;
   localparam int     ITEMS_PER_SET  = 180;
   localparam int     HOLD_AT        = 100;
   localparam int     HOLD_CYCLES    = 700;
   localparam longint CYCLE_LIMIT    = 4_000_000;
   localparam longint ERR_LO         = -262144;
   localparam longint ERR_HI         = 262143;
   localparam longint TURN_LO        = -32768;
   localparam longint TURN_HI        = 32767;

   typedef struct {
      logic [BEARING_W-1:0]         target;
      logic [BEARING_W-1:0]         north;
      logic signed [ROTATION_W-1:0] rot;
      logic [DIST_W-1:0]            distance;
   } heading_req_type;

   typedef struct {
      logic [PULSE_W-1:0]       left;
      logic [PULSE_W-1:0]       right;
      logic signed [TURN_W-1:0] turn;
   } drive_cmd_type;

   typedef struct {
      csr_reg_type       idx;
      logic [GAIN_W-1:0] data;
   } csr_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid            = 1'b0;
   logic                         req_ready;
   logic [BEARING_W-1:0]         req_target_bearing   = '0;
   logic [BEARING_W-1:0]         req_north_bearing    = '0;
   logic signed [ROTATION_W-1:0] req_compass_rotation = '0;
   logic [DIST_W-1:0]            req_distance_dm      = '0;
   logic                         rsp_valid;
   logic                         rsp_ready            = 1'b0;
   logic [PULSE_W-1:0]           rsp_left_pulse_us;
   logic [PULSE_W-1:0]           rsp_right_pulse_us;
   logic signed [TURN_W-1:0]     rsp_turn_command;
   logic                         csr_valid            = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index            = '0;
   logic [GAIN_W-1:0]            csr_data             = '0;

   // predictor copy of the registers and loop state
   logic signed [GAIN_W-1:0]             gain_p       = KP_RESET;
   logic signed [GAIN_W-1:0]             gain_i       = KI_RESET;
   logic signed [GAIN_W-1:0]             gain_d       = KD_RESET;
   logic [GAIN_W-1:0]                    tick_period  = LOOP_PERIOD_RESET;
   logic [GAIN_W-1:0]                    tick_rate    = INVERSE_PERIOD_RESET;
   logic signed [GAIN_W-1:0]             cruise_speed = FORWARD_SPEED_RESET;
   logic [GAIN_W-1:0]                    stop_radius  = ARRIVAL_RADIUS_RESET;
   logic signed [ERR_W-1:0]              prev_heading_err = '0;
   logic signed [INTEGRAL_WIDTH_DEF-1:0] heading_integral = '0;

   heading_req_type heading_reqs_pending[$];
   csr_write_type   csr_writes_pending[$];
   drive_cmd_type   drive_cmds_due[$];

   int     fail_count   = 0;
   int     reqs_queued  = 0;
   int     reqs_taken   = 0;
   int     reqs_dropped = 0;
   int     cmds_checked = 0;
   int     csr_queued   = 0;
   int     csr_writes   = 0;
   int     req_gap      = 0;
   int     req_quiet    = 0;
   int     rsp_gap      = 0;
   int     rsp_quiet    = 0;
   int     rsp_taken    = 0;
   longint cycle_count  = 0;

   heading_pid_differential_drive u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_target_bearing   (req_target_bearing),
      .req_north_bearing    (req_north_bearing),
      .req_compass_rotation (req_compass_rotation),
      .req_distance_dm      (req_distance_dm),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_left_pulse_us    (rsp_left_pulse_us),
      .rsp_right_pulse_us   (rsp_right_pulse_us),
      .rsp_turn_command     (rsp_turn_command),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint clamp64(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [PULSE_W-1:0] pulse_width(input longint side);
      return PULSE_W'(longint'(PULSE_CENTRE) +
                      ((100 * side + longint'(PULSE_ROUND)) >>> PULSE_FRAC));
   endfunction

   // Returns 0 when the request falls inside the arrival radius.
   function automatic bit predict_drive(input heading_req_type rq, output drive_cmd_type cmd);
      longint err, deriv, acc, turn, ilim;
      cmd = '{left: '0, right: '0, turn: '0};
      if (rq.distance < stop_radius) return 1'b0;
      err = clamp64(longint'(rq.target) - longint'(rq.north) - longint'(rq.rot),
                    ERR_LO, ERR_HI);
      ilim = longint'(1) <<< (INTEGRAL_WIDTH_DEF - 1);
      heading_integral = clamp64(longint'(heading_integral) + err * longint'(tick_period),
                                 -ilim, ilim - 1);
      deriv = (err - longint'(prev_heading_err)) * longint'(tick_rate);
      prev_heading_err = err[ERR_W-1:0];
      acc = longint'(gain_p) * err + longint'(gain_d) * deriv +
            ((longint'(gain_i) * longint'(heading_integral)) >>> KI_SHIFT);
      acc = acc >>> (ANGLE_FRAC_BITS_DEF - 7);
      turn = clamp64(acc, TURN_LO, TURN_HI);
      cmd.turn  = turn[TURN_W-1:0];
      cmd.left  = pulse_width(clamp64(longint'(cruise_speed) + turn,
                                      longint'(SIDE_MIN), longint'(SIDE_MAX)));
      cmd.right = pulse_width(clamp64(longint'(cruise_speed) - turn,
                                      longint'(SIDE_MIN), longint'(SIDE_MAX)));
      return 1'b1;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a run with none.
   function automatic int next_gap(inout int quiet);
      int r;
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 2) quiet = $urandom_range(60, 20);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 96) return $urandom_range(20, 4);
      return $urandom_range(250, 40);
   endfunction

   always @(posedge clock) begin : req_driver
      heading_req_type rq;
      drive_cmd_type   cmd;
      bit              nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv = req_valid;
         if (req_valid && req_ready) begin
            rq.target   = req_target_bearing;
            rq.north    = req_north_bearing;
            rq.rot      = req_compass_rotation;
            rq.distance = req_distance_dm;
            if (predict_drive(rq, cmd)) drive_cmds_due.push_back(cmd);
            else reqs_dropped++;
            reqs_taken++;
            nv = 1'b0;
            req_gap = next_gap(req_quiet);
         end
         if (!nv) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (heading_reqs_pending.size() != 0) begin
               rq = heading_reqs_pending.pop_front();
               req_target_bearing   <= rq.target;
               req_north_bearing    <= rq.north;
               req_compass_rotation <= rq.rot;
               req_distance_dm      <= rq.distance;
               nv = 1'b1;
            end
         end
         req_valid <= nv;
      end
   end

   always @(posedge clock) begin : csr_driver
      csr_write_type w;
      bit            nv;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         nv = csr_valid;
         if (csr_valid && csr_ready) begin
            case (csr_reg_type'(csr_index))
               CSR_KP_GAIN:        gain_p       = csr_data;
               CSR_KI_GAIN:        gain_i       = csr_data;
               CSR_KD_GAIN:        gain_d       = csr_data;
               CSR_LOOP_PERIOD:    tick_period  = csr_data;
               CSR_INVERSE_PERIOD: tick_rate    = csr_data;
               CSR_FORWARD_SPEED:  cruise_speed = csr_data;
               CSR_ARRIVAL_RADIUS: stop_radius  = csr_data;
               default: ;
            endcase
            csr_writes++;
            nv = 1'b0;
         end
         if (!nv && csr_writes_pending.size() != 0) begin
            w = csr_writes_pending.pop_front();
            csr_index <= w.idx;
            csr_data  <= w.data;
            nv = 1'b1;
         end
         csr_valid <= nv;
      end
   end

   // hold off once for a long stretch so the block fills up
   always @(posedge clock) begin : rsp_pacer
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_taken++;
            rsp_gap = (rsp_taken == HOLD_AT) ? HOLD_CYCLES : next_gap(rsp_quiet);
         end else if (rsp_gap > 0) begin
            rsp_gap--;
         end
         rsp_ready <= (rsp_gap == 0);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      drive_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_cmds_due.size() == 0) begin
            $error("unexpected result: left %0d right %0d turn %0d",
                   rsp_left_pulse_us, rsp_right_pulse_us, rsp_turn_command);
            fail_count++;
         end else begin
            want = drive_cmds_due.pop_front();
            if (rsp_left_pulse_us !== want.left) begin
               $error("left_pulse_us: expected %0d, got %0d", want.left, rsp_left_pulse_us);
               fail_count++;
            end
            if (rsp_right_pulse_us !== want.right) begin
               $error("right_pulse_us: expected %0d, got %0d", want.right, rsp_right_pulse_us);
               fail_count++;
            end
            if (rsp_turn_command !== want.turn) begin
               $error("turn_command: expected %0d, got %0d", want.turn, rsp_turn_command);
               fail_count++;
            end
            cmds_checked++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, drive_cmds_due.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic queue_request(input int t, input int n, input int r, input int d);
      heading_req_type rq;
      rq.target   = BEARING_W'(t);
      rq.north    = BEARING_W'(n);
      rq.rot      = ROTATION_W'(r);
      rq.distance = DIST_W'(d);
      heading_reqs_pending.push_back(rq);
      reqs_queued++;
   endtask

   task automatic settle();
      while (reqs_taken != reqs_queued || drive_cmds_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register settings in index order: kp, ki, kd, loop, inverse, speed, radius
   logic [GAIN_W-1:0] reg_plan [4][7] = '{
      '{16'd64,   16'd200,  16'd30,   16'hffff, 16'd1,    16'd0,    16'd0},
      '{16'h8000, 16'h8000, 16'h8000, 16'd0,    16'd0,    16'h8000, 16'd0},
      '{16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff, 16'h7fff, 16'hffff},
      '{16'd3,    16'd1,    16'hfffe, 16'd1,    16'd3,    16'd8000, 16'd1000}
   };

   initial begin : stimulus
      csr_write_type w;
      int            ph, k, style, base, off, tgt;
      int            t_v, n_v, r_v, d_v;
      bit            bias_up;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, arrival boundary, saturating turn and both signs
      queue_request(0, 0, 0, 30);
      queue_request(0, 0, 0, 29);
      queue_request(0, 0, 0, 0);
      queue_request(100, 0, 0, 65535);
      queue_request(131071, 0, -131072, 1000);
      queue_request(0, 131071, 131071, 1000);
      queue_request(92159, 0, 0, 500);
      queue_request(0, 92159, 0, 500);
      queue_request(0, 0, 92159, 500);
      queue_request(0, 0, -92159, 500);
      queue_request(46080, 46080, 0, 31);
      queue_request(1, 0, 0, 40);
      queue_request(0, 1, 0, 40);
      queue_request(300, 0, 0, 100);
      queue_request(0, 300, 0, 100);
      queue_request(65536, 65535, 1, 200);
      queue_request(131071, 131071, 0, 65535);
      queue_request(0, 0, -1, 30);
      queue_request(5000, 4000, -200, 12);
      queue_request(256, 0, 0, 1000);
      queue_request(0, 0, -256, 1000);
      queue_request(131071, 0, 131071, 2000);
      settle();

      bias_up = 1'b1;
      for (ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            for (k = 0; k < 7; k++) begin
               w.idx  = csr_reg_type'(k);
               w.data = (ph <= 4) ? reg_plan[ph-1][k] : GAIN_W'($urandom());
               if (ph == 5 && k == CSR_ARRIVAL_RADIUS) w.data = GAIN_W'($urandom_range(2000));
               if (ph == 5 && k == CSR_KD_GAIN) w.data = GAIN_W'($urandom_range(64)) - 16'd32;
               csr_writes_pending.push_back(w);
               csr_queued++;
            end
            while (csr_writes != csr_queued) @(posedge clock);
         end
         for (k = 0; k < ITEMS_PER_SET; k++) begin
            if (k % 40 == 0) bias_up = 1'($urandom_range(1));
            style = $urandom_range(9);
            if (style <= 3) begin
               t_v = $urandom_range(92159);
               n_v = $urandom_range(92159);
               r_v = int'($urandom_range(184318)) - 92159;
            end else if (style <= 5) begin
               // small heading error around a random compass state
               base = $urandom_range(92159);
               off  = int'($urandom_range(4000)) - 2000;
               tgt  = base + off + int'($urandom_range(800)) - 400;
               t_v  = (tgt < 0) ? 0 : ((tgt > 131071) ? 131071 : tgt);
               n_v  = base;
               r_v  = off;
            end else if (style == 6) begin
               t_v = $urandom();
               n_v = $urandom();
               r_v = $urandom();
            end else if (bias_up) begin
               // hold the error sign to drive the integral into saturation
               t_v = $urandom_range(131071, 60000);
               n_v = $urandom_range(5000);
               r_v = -int'($urandom_range(20000));
            end else begin
               t_v = $urandom_range(5000);
               n_v = $urandom_range(131071, 60000);
               r_v = $urandom_range(20000);
            end
            if (stop_radius != 0 && $urandom_range(9) == 0)
               d_v = $urandom_range(int'(stop_radius) - 1);
            else
               d_v = $urandom_range(65535, int'(stop_radius));
            queue_request(t_v, n_v, r_v, d_v);
         end
         settle();
      end

      $display("Covered %0d requests under 6 register settings (%0d writes): %0d results checked,",
               reqs_taken, csr_writes, cmds_checked);
      $display("%0d requests dropped inside the arrival radius, one long output stall.",
               reqs_dropped);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/hpdd_pkg.sv
hw/rtl/hpdd_smul.sv
hw/rtl/heading_pid_differential_drive.sv
hw/rtl/hpdd_checker.sv
tb/sv/tb_top.sv
